// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions; expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dtfb_pkg.sv
// ---------------------------------------------------------------------------
// dtfb_pkg
// Shared widths, codes and command types of the depth-tested frame buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package dtfb_pkg;

  localparam int COLOR_W    = 32;
  localparam int POS_W      = 16;
  localparam int DIM_W      = 9;
  localparam int CMP_W      = 13;   // holds any frame dimension up to 4096
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = DIM_W'(256);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CLEAR_COLOR  = 2'd2,
    REG_CLEAR_DEPTH  = 2'd3
  } cfg_idx_t;

  // Work the back end has to do for one word.
  typedef enum logic [1:0] {
    K_NONE,    // answer only, no store access
    K_DRAW,
    K_READ,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  oob;
    logic  test_on;
    logic  clr_color;
    logic  clr_depth;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/dtfb_ram.sv
// ---------------------------------------------------------------------------
// dtfb_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module dtfb_ram #(
  parameter int DATA_W = dtfb_pkg::COLOR_W,
  parameter int DEPTH  = dtfb_pkg::MAX_WIDTH_DEF * dtfb_pkg::MAX_HEIGHT_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dtfb_front.sv
// ---------------------------------------------------------------------------
// dtfb_front
// Accepts input words, checks bounds and turns them into store commands.
// ---------------------------------------------------------------------------
`default_nettype none

module dtfb_front #(
  parameter int MAX_WIDTH  = dtfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtfb_pkg::MAX_HEIGHT_DEF,
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic signed [dtfb_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [dtfb_pkg::POS_W-1:0] pos_y,
  input  wire logic                            depth_test_on,
  input  wire logic                            clear_colors,
  input  wire logic                            clear_depths,
  input  wire logic [dtfb_pkg::DIM_W-1:0]      used_w,
  input  wire logic [dtfb_pkg::DIM_W-1:0]      used_h,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output dtfb_pkg::ctl_t                       push_ctl,
  output logic [AW-1:0]                        push_addr
);

  logic [dtfb_pkg::POS_W-1:0] x_u;
  logic [dtfb_pkg::POS_W-1:0] y_u;
  logic                       x_oob;
  logic                       y_oob;
  logic                       pos_oob;
  logic                       frame_empty;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign x_u   = $unsigned(pos_x);
  assign y_u   = $unsigned(pos_y);
  assign x_oob = x_u[dtfb_pkg::POS_W-1] || (x_u >= dtfb_pkg::POS_W'(used_w));
  assign y_oob = y_u[dtfb_pkg::POS_W-1] || (y_u >= dtfb_pkg::POS_W'(used_h));
  assign pos_oob     = x_oob || y_oob;
  assign frame_empty = (used_w == '0) || (used_h == '0);

  // Row-major store address; only meaningful for in-frame positions.
  assign push_addr = AW'(y_u[YW-1:0]) * AW'(MAX_WIDTH) + AW'(x_u[XW-1:0]);

  always_comb begin
    push_ctl           = '0;
    push_ctl.kind      = dtfb_pkg::K_NONE;
    push_ctl.test_on   = depth_test_on;
    push_ctl.clr_color = clear_colors;
    push_ctl.clr_depth = clear_depths;
    case (dtfb_pkg::op_t'(opcode))
      dtfb_pkg::OP_DRAW: begin
        push_ctl.oob  = pos_oob;
        push_ctl.kind = pos_oob ? dtfb_pkg::K_NONE : dtfb_pkg::K_DRAW;
      end
      dtfb_pkg::OP_READ: begin
        push_ctl.oob  = pos_oob;
        push_ctl.kind = pos_oob ? dtfb_pkg::K_NONE : dtfb_pkg::K_READ;
      end
      dtfb_pkg::OP_CLEAR: begin
        // An empty frame has nothing to walk.
        push_ctl.kind = frame_empty ? dtfb_pkg::K_NONE : dtfb_pkg::K_CLEAR;
      end
      default: begin
        push_ctl.kind = dtfb_pkg::K_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dtfb_queue.sv
// ---------------------------------------------------------------------------
// dtfb_queue
// Short command FIFO between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module dtfb_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [DW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop,
  output logic      [DW-1:0] pop_data
);

  logic [DW-1:0]                   q_r [dtfb_pkg::Q_DEPTH];
  logic [dtfb_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [dtfb_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [dtfb_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                            do_push;
  logic                            do_pop;

  localparam logic [dtfb_pkg::Q_PTR_W-1:0] PTR_LAST =
    dtfb_pkg::Q_PTR_W'(dtfb_pkg::Q_DEPTH - 1);

  assign push_ready = (cnt_r != dtfb_pkg::Q_CNT_W'(dtfb_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dtfb_back.sv
// ---------------------------------------------------------------------------
// dtfb_back
// Carries out store commands: depth-tested draws, reads and clear walks.
// ---------------------------------------------------------------------------
`default_nettype none

module dtfb_back #(
  parameter int MAX_WIDTH  = dtfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtfb_pkg::MAX_HEIGHT_DEF,
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  input  wire dtfb_pkg::ctl_t                     q_ctl,
  input  wire logic [AW-1:0]                      q_addr,
  input  wire logic signed [dtfb_pkg::POS_W-1:0]  q_z,
  input  wire logic [dtfb_pkg::COLOR_W-1:0]       q_color,
  input  wire logic [dtfb_pkg::DIM_W-1:0]         used_w,
  input  wire logic [dtfb_pkg::DIM_W-1:0]         used_h,
  input  wire logic [dtfb_pkg::COLOR_W-1:0]       clear_color,
  input  wire logic [dtfb_pkg::POS_W-1:0]         clear_depth,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [dtfb_pkg::COLOR_W-1:0]            out_read_color,
  output logic                                    out_was_written,
  output logic                                    out_out_of_bounds
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CLEAR,
    S_CDONE
  } state_t;

  localparam int CW = dtfb_pkg::CMP_W;

  state_t                              state_r, state_nxt;
  dtfb_pkg::ctl_t                      cur_ctl_r, cur_ctl_nxt;
  logic [AW-1:0]                       cur_addr_r, cur_addr_nxt;
  logic signed [dtfb_pkg::POS_W-1:0]   cur_z_r, cur_z_nxt;
  logic [dtfb_pkg::COLOR_W-1:0]        cur_color_r, cur_color_nxt;
  logic [XW-1:0]                       col_r, col_nxt;
  logic [YW-1:0]                       row_r, row_nxt;
  logic [AW-1:0]                       base_r, base_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [dtfb_pkg::COLOR_W-1:0]        out_color_r, out_color_nxt;
  logic                                out_wr_r, out_wr_nxt;
  logic                                out_oob_r, out_oob_nxt;

  logic                                slot_free;
  logic                                last_col;
  logic                                last_row;
  logic                                depth_hit;

  logic                                c_we, c_re;
  logic [AW-1:0]                       c_waddr;
  logic [dtfb_pkg::COLOR_W-1:0]        c_wdata, c_rdata;
  logic                                d_we, d_re;
  logic [AW-1:0]                       d_waddr;
  logic [dtfb_pkg::POS_W-1:0]          d_wdata, d_rdata;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid && slot_free;
  assign last_col  = (CW'(col_r) + CW'(1)) == CW'(used_w);
  assign last_row  = (CW'(row_r) + CW'(1)) == CW'(used_h);
  assign depth_hit = $signed(d_rdata) < cur_z_r;

  always_comb begin
    state_nxt     = state_r;
    cur_ctl_nxt   = cur_ctl_r;
    cur_addr_nxt  = cur_addr_r;
    cur_z_nxt     = cur_z_r;
    cur_color_nxt = cur_color_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_color_nxt = out_color_r;
    out_wr_nxt    = out_wr_r;
    out_oob_nxt   = out_oob_r;
    c_we    = 1'b0;
    c_waddr = q_addr;
    c_wdata = q_color;
    c_re    = 1'b0;
    d_we    = 1'b0;
    d_waddr = q_addr;
    d_wdata = q_z;
    d_re    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cur_ctl_nxt   = q_ctl;
          cur_addr_nxt  = q_addr;
          cur_z_nxt     = q_z;
          cur_color_nxt = q_color;
          case (q_ctl.kind)
            dtfb_pkg::K_DRAW: begin
              if (q_ctl.test_on) begin
                d_re      = 1'b1;
                state_nxt = S_RD;
              end else begin
                // Untested draw: color only, depth left alone.
                c_we          = 1'b1;
                out_valid_nxt = 1'b1;
                out_color_nxt = '0;
                out_wr_nxt    = 1'b1;
                out_oob_nxt   = 1'b0;
              end
            end
            dtfb_pkg::K_READ: begin
              c_re      = 1'b1;
              state_nxt = S_RD;
            end
            dtfb_pkg::K_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              base_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_color_nxt = '0;
              out_wr_nxt    = 1'b0;
              out_oob_nxt   = q_ctl.oob;
            end
          endcase
        end
      end

      S_RD: begin
        c_waddr = cur_addr_r;
        c_wdata = cur_color_r;
        d_waddr = cur_addr_r;
        d_wdata = cur_z_r;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_oob_nxt   = 1'b0;
          if (cur_ctl_r.kind == dtfb_pkg::K_READ) begin
            out_color_nxt = c_rdata;
            out_wr_nxt    = 1'b0;
          end else begin
            // Larger z wins: write both stores on a hit.
            c_we          = depth_hit;
            d_we          = depth_hit;
            out_color_nxt = '0;
            out_wr_nxt    = depth_hit;
          end
          state_nxt = S_IDLE;
        end
      end

      S_CLEAR: begin
        c_waddr = base_r + AW'(col_r);
        c_wdata = clear_color;
        d_waddr = base_r + AW'(col_r);
        d_wdata = clear_depth;
        c_we    = cur_ctl_r.clr_color;
        d_we    = cur_ctl_r.clr_depth;
        if (last_col) begin
          col_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + AW'(MAX_WIDTH);
          if (last_row) begin
            state_nxt = S_CDONE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end

      S_CDONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = '0;
          out_wr_nxt    = 1'b0;
          out_oob_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
    end
    cur_ctl_r   <= cur_ctl_nxt;
    cur_addr_r  <= cur_addr_nxt;
    cur_z_r     <= cur_z_nxt;
    cur_color_r <= cur_color_nxt;
    out_color_r <= out_color_nxt;
    out_wr_r    <= out_wr_nxt;
    out_oob_r   <= out_oob_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_color    = out_color_r;
  assign out_was_written   = out_wr_r;
  assign out_out_of_bounds = out_oob_r;

  dtfb_ram #(
    .DATA_W (dtfb_pkg::COLOR_W),
    .DEPTH  (DEPTH)
  ) u_color_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (q_addr),
    .rdata (c_rdata)
  );

  dtfb_ram #(
    .DATA_W (dtfb_pkg::POS_W),
    .DEPTH  (DEPTH)
  ) u_depth_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (q_addr),
    .rdata (d_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/depth_tested_frame_buffer.sv
// ---------------------------------------------------------------------------
// depth_tested_frame_buffer
// Z-buffered point frame buffer: draw, clear and read over color/depth stores.
// ---------------------------------------------------------------------------
//   channel  | handshake            | payload
//   in_      | in_valid / in_ready  | opcode, pos_x/y/z, point_color, flags
//   out_     | out_valid / out_ready| read_color, was_written, out_of_bounds
//   cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// Untested draw and out-of-frame or unused words: answered straight from S_IDLE.
// Depth-tested draw and read: pass S_RD, for the stores' registered read port.
// Clear: walks used width * used height pixels, one written per cycle.
// Two command words queue ahead of the back end; a held result blocks only it.
// Reset does not touch the stores: they hold garbage until a clear covers them.
// ---------------------------------------------------------------------------
`default_nettype none

module depth_tested_frame_buffer #(
  parameter int MAX_WIDTH  = dtfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtfb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,

  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_opcode,
  input  wire logic signed [dtfb_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [dtfb_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic signed [dtfb_pkg::POS_W-1:0]    in_pos_z,
  input  wire logic [dtfb_pkg::COLOR_W-1:0]         in_point_color,
  input  wire logic                                 in_depth_test_on,
  input  wire logic                                 in_clear_colors,
  input  wire logic                                 in_clear_depths,

  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [dtfb_pkg::COLOR_W-1:0]              out_read_color,
  output logic                                      out_was_written,
  output logic                                      out_out_of_bounds,

  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dtfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dtfb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = $bits(dtfb_pkg::ctl_t) + AW + dtfb_pkg::POS_W + dtfb_pkg::COLOR_W;
  localparam logic [dtfb_pkg::CMP_W-1:0] MW = dtfb_pkg::CMP_W'(MAX_WIDTH);
  localparam logic [dtfb_pkg::CMP_W-1:0] MH = dtfb_pkg::CMP_W'(MAX_HEIGHT);

  logic [dtfb_pkg::DIM_W-1:0]     frame_w_r;
  logic [dtfb_pkg::DIM_W-1:0]     frame_h_r;
  logic [dtfb_pkg::COLOR_W-1:0]   clear_color_r;
  logic [dtfb_pkg::POS_W-1:0]     clear_depth_r;
  logic [dtfb_pkg::DIM_W-1:0]     used_w;
  logic [dtfb_pkg::DIM_W-1:0]     used_h;

  logic                           push_valid;
  logic                           push_ready;
  dtfb_pkg::ctl_t                 push_ctl;
  logic [AW-1:0]                  push_addr;
  logic [QW-1:0]                  push_data;

  logic                           q_valid;
  logic                           q_pop;
  logic [QW-1:0]                  q_data;
  dtfb_pkg::ctl_t                 q_ctl;
  logic [AW-1:0]                  q_addr;
  logic signed [dtfb_pkg::POS_W-1:0] q_z;
  logic [dtfb_pkg::COLOR_W-1:0]   q_color;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r     <= dtfb_pkg::FRAME_DIM_RESET;
      frame_h_r     <= dtfb_pkg::FRAME_DIM_RESET;
      clear_color_r <= '0;
      clear_depth_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (dtfb_pkg::cfg_idx_t'(cfg_index))
        dtfb_pkg::REG_FRAME_WIDTH:  frame_w_r     <= cfg_data[dtfb_pkg::DIM_W-1:0];
        dtfb_pkg::REG_FRAME_HEIGHT: frame_h_r     <= cfg_data[dtfb_pkg::DIM_W-1:0];
        dtfb_pkg::REG_CLEAR_COLOR:  clear_color_r <= cfg_data[dtfb_pkg::COLOR_W-1:0];
        dtfb_pkg::REG_CLEAR_DEPTH:  clear_depth_r <= cfg_data[dtfb_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame to the store size.
  assign used_w = (dtfb_pkg::CMP_W'(frame_w_r) > MW) ? MW[dtfb_pkg::DIM_W-1:0] : frame_w_r;
  assign used_h = (dtfb_pkg::CMP_W'(frame_h_r) > MH) ? MH[dtfb_pkg::DIM_W-1:0] : frame_h_r;

  dtfb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (in_opcode),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .depth_test_on (in_depth_test_on),
    .clear_colors  (in_clear_colors),
    .clear_depths  (in_clear_depths),
    .used_w        (used_w),
    .used_h        (used_h),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_ctl      (push_ctl),
    .push_addr     (push_addr)
  );

  assign push_data = {push_ctl, push_addr, in_pos_z, in_point_color};

  dtfb_queue #(
    .DW (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign {q_ctl, q_addr, q_z, q_color} = q_data;

  dtfb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_ctl             (q_ctl),
    .q_addr            (q_addr),
    .q_z               (q_z),
    .q_color           (q_color),
    .used_w            (used_w),
    .used_h            (used_h),
    .clear_color       (clear_color_r),
    .clear_depth       (clear_depth_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_color    (out_read_color),
    .out_was_written   (out_was_written),
    .out_out_of_bounds (out_out_of_bounds)
  );

endmodule

`default_nettype wire

// File: rtl/dtfb_checker.sv
// ---------------------------------------------------------------------------
// dtfb_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtfb_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [dtfb_pkg::COLOR_W-1:0]   out_read_color,
  input wire logic                           out_was_written,
  input wire logic                           out_out_of_bounds
);

  // A held result keeps its word.
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_color) && $stable(out_was_written) && $stable(out_out_of_bounds))

  // A point outside the frame is never written.
  `ASSERT_IMP(a_oob_no_write, out_valid && out_out_of_bounds, !out_was_written)

  // Only reads return color; written draws and out-of-frame words answer zero.
  `ASSERT_IMP(a_color_only_read, out_valid && (out_was_written || out_out_of_bounds), out_read_color == '0)

  // No result comes out of reset.
  `ASSERT_RST_NXT(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind depth_tested_frame_buffer dtfb_checker u_dtfb_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the depth-tested frame buffer. A scripted opening
// covers frame edges, depth ties, one-store clears, empty and oversize frames
// and the unused opcode. Random phases follow, each with its own frame setup.
// Answers checked in order: scripted ones fixed, the rest z-buffer predicted.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int COLS = dtfb_pkg::MAX_WIDTH_DEF;
  localparam int ROWS = dtfb_pkg::MAX_HEIGHT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1030;
  localparam int BACKLOG_CYCLES = 400;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        color;
    logic               test_on;
    logic               clr_color;
    logic               clr_depth;
  } word_t;

  typedef struct packed {
    logic [31:0] color;
    logic        written;
    logic        oob;
  } answer_t;

  typedef struct packed {
    logic                 is_reg;
    dtfb_pkg::cfg_idx_t   reg_sel;
    logic [31:0]          reg_val;
    word_t                w;
    logic                 typed;
    answer_t              ans;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [15:0] in_pos_z;
  logic [31:0] in_point_color;
  logic in_depth_test_on;
  logic in_clear_colors;
  logic in_clear_depths;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_read_color;
  logic out_was_written;
  logic out_out_of_bounds;
  logic cfg_valid;
  logic cfg_ready;
  logic [dtfb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dtfb_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state: stores, which entries hold data, and the registers
  logic [31:0]        color_mem [0:COLS*ROWS-1];
  logic signed [15:0] depth_mem [0:COLS*ROWS-1];
  bit                 color_set [0:COLS*ROWS-1];
  bit                 depth_set [0:COLS*ROWS-1];
  logic [8:0]         frame_w;
  logic [8:0]         frame_h;
  logic [31:0]        clr_color_reg;
  logic signed [15:0] clr_depth_reg;

  answer_t due_answers[$];
  row_t    script[$];

  int mismatches;
  int words_taken;
  int answers_seen;
  int draws_landed;
  int reads_hit;
  int clears_done;
  int outside_count;
  int frame_setups;
  int burst_left;
  bit streaming;
  bit backlog_done;
  bit cfg_open;

  depth_tested_frame_buffer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_point_color    (in_point_color),
    .in_depth_test_on  (in_depth_test_on),
    .in_clear_colors   (in_clear_colors),
    .in_clear_depths   (in_clear_depths),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_color    (out_read_color),
    .out_was_written   (out_was_written),
    .out_out_of_bounds (out_out_of_bounds),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d answers outstanding", due_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int used_w();
    return (frame_w > COLS) ? COLS : int'(frame_w);
  endfunction

  function automatic int used_h();
    return (frame_h > ROWS) ? ROWS : int'(frame_h);
  endfunction

  function automatic bit pixel_at(logic signed [15:0] x, logic signed [15:0] y,
                                  output int idx);
    int xi;
    int yi;
    xi = x;
    yi = y;
    idx = 0;
    if (xi < 0 || yi < 0 || xi >= used_w() || yi >= used_h()) return 1'b0;
    idx = yi * COLS + xi;
    return 1'b1;
  endfunction

  // z-buffer update for one word; returns the answer the block owes for it
  function automatic answer_t zbuf_predict(word_t w);
    answer_t a;
    int idx;
    int r;
    int c;
    bit hit;
    a = '0;
    hit = pixel_at(w.x, w.y, idx);
    case (w.opcode)
      dtfb_pkg::OP_DRAW: begin
        if (!hit) begin
          a.oob = 1'b1;
        end else if (!w.test_on || depth_mem[idx] < w.z) begin
          color_mem[idx] = w.color;
          color_set[idx] = 1'b1;
          if (w.test_on) depth_mem[idx] = w.z;
          a.written = 1'b1;
          draws_landed++;
        end
      end
      dtfb_pkg::OP_CLEAR: begin
        for (r = 0; r < used_h(); r++) begin
          for (c = 0; c < used_w(); c++) begin
            idx = r * COLS + c;
            if (w.clr_color) begin
              color_mem[idx] = clr_color_reg;
              color_set[idx] = 1'b1;
            end
            if (w.clr_depth) begin
              depth_mem[idx] = clr_depth_reg;
              depth_set[idx] = 1'b1;
            end
          end
        end
        clears_done++;
      end
      dtfb_pkg::OP_READ: begin
        if (hit) begin
          a.color = color_mem[idx];
          reads_hit++;
        end else begin
          a.oob = 1'b1;
        end
      end
      default: ;
    endcase
    if (a.oob) outside_count++;
    return a;
  endfunction

  function automatic void put_reg(dtfb_pkg::cfg_idx_t sel, logic [31:0] val);
    row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    script.push_back(r);
  endfunction

  // flags: {depth test, clear colors, clear depths}
  function automatic void put_word(logic [1:0] op, int x, int y, int z, logic [31:0] color,
                                   logic [2:0] flags, bit typed = 1'b0,
                                   logic [31:0] rc = '0, bit wr = 1'b0, bit oob = 1'b0);
    row_t r;
    r = '0;
    r.w.opcode = op;
    r.w.x = 16'(x);
    r.w.y = 16'(y);
    r.w.z = 16'(z);
    r.w.color = color;
    {r.w.test_on, r.w.clr_color, r.w.clr_depth} = flags;
    r.typed = typed;
    r.ans.color = rc;
    r.ans.written = wr;
    r.ans.oob = oob;
    script.push_back(r);
  endfunction

  function automatic word_t pick_word();
    word_t w;
    int uw;
    int uh;
    int r;
    int idx;
    uw = used_w();
    uh = used_h();
    w.opcode = dtfb_pkg::OP_DRAW;
    w.x = 16'($urandom);
    w.y = 16'($urandom);
    r = $urandom_range(9, 0);
    w.z = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'($urandom);
    w.color = $urandom;
    w.test_on = ($urandom_range(3, 0) != 0);
    w.clr_color = 1'($urandom_range(1, 0));
    w.clr_depth = 1'($urandom_range(1, 0));
    r = $urandom_range(99, 0);
    if (r < 70 && uw > 0 && uh > 0) begin
      w.x = 16'($urandom_range(uw - 1, 0));
      w.y = 16'($urandom_range(uh - 1, 0));
      if (r < 5) begin
        w.opcode = dtfb_pkg::OP_CLEAR;
        if ($urandom_range(2, 0) != 0) {w.clr_color, w.clr_depth} = 2'b11;
      end else if (r < 40) begin
        w.opcode = dtfb_pkg::OP_DRAW;
      end else begin
        w.opcode = dtfb_pkg::OP_READ;
      end
    end else if (r < 85) begin
      w.opcode = 2'($urandom_range(3, 0));
    end else begin
      // just inside and just outside the frame edges
      case ($urandom_range(3, 0))
        0: w.x = -16'sd1;
        1: w.x = 16'(uw);
        2: w.x = 16'(uw - 1);
        default: w.x = '0;
      endcase
      case ($urandom_range(3, 0))
        0: w.y = -16'sd1;
        1: w.y = 16'(uh);
        2: w.y = 16'(uh - 1);
        default: w.y = '0;
      endcase
      w.opcode = $urandom_range(1, 0) ? dtfb_pkg::OP_DRAW : dtfb_pkg::OP_READ;
    end
    // never look at a store entry that holds no data yet
    if (pixel_at(w.x, w.y, idx)) begin
      if (w.opcode == dtfb_pkg::OP_READ && !color_set[idx]) begin
        w.opcode = dtfb_pkg::OP_DRAW;
        w.test_on = 1'b0;
      end else if (w.opcode == dtfb_pkg::OP_DRAW && w.test_on && !depth_set[idx]) begin
        w.test_on = 1'b0;
      end
    end
    return w;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // hold the word until taken, then book its answer
  task automatic offer_word(input word_t w, input bit typed, input answer_t fixed);
    answer_t want;
    in_valid <= 1'b1;
    in_opcode <= w.opcode;
    in_pos_x <= w.x;
    in_pos_y <= w.y;
    in_pos_z <= w.z;
    in_point_color <= w.color;
    in_depth_test_on <= w.test_on;
    in_clear_colors <= w.clr_color;
    in_clear_depths <= w.clr_depth;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = zbuf_predict(w);
    due_answers.push_back(typed ? fixed : want);
    words_taken++;
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40)
                                                : $urandom_range(16, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // drain everything before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input dtfb_pkg::cfg_idx_t sel, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      dtfb_pkg::REG_FRAME_WIDTH:  frame_w = val[8:0];
      dtfb_pkg::REG_FRAME_HEIGHT: frame_h = val[8:0];
      dtfb_pkg::REG_CLEAR_COLOR:  clr_color_reg = val;
      dtfb_pkg::REG_CLEAR_DEPTH:  clr_depth_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // small frames mostly; full-width, full-height, oversize and empty now and then
  task automatic pick_frame();
    int r;
    int w;
    int h;
    logic [15:0] cd;
    r = $urandom_range(99, 0);
    if (r < 70) begin
      w = $urandom_range(16, 1);
      h = $urandom_range(16, 1);
    end else if (r < 80) begin
      w = COLS;
      h = $urandom_range(4, 1);
    end else if (r < 85) begin
      w = $urandom_range(511, 257);
      h = $urandom_range(3, 1);
    end else if (r < 90) begin
      w = $urandom_range(3, 1);
      h = $urandom_range(511, 256);
    end else if (r < 95) begin
      w = $urandom_range(1, 0) ? 0 : $urandom_range(511, 0);
      h = (w == 0) ? $urandom_range(511, 0) : 0;
    end else begin
      w = 1;
      h = 1;
    end
    r = $urandom_range(9, 0);
    cd = (r < 2) ? 16'h8000 : (r < 4) ? 16'h7FFF : 16'($urandom);
    write_reg(dtfb_pkg::REG_FRAME_WIDTH, {23'($urandom), 9'(w)});
    write_reg(dtfb_pkg::REG_FRAME_HEIGHT, {23'($urandom), 9'(h)});
    write_reg(dtfb_pkg::REG_CLEAR_COLOR, $urandom);
    write_reg(dtfb_pkg::REG_CLEAR_DEPTH, {16'($urandom), cd});
    frame_setups++;
  endtask

  always @(posedge clk) begin : answer_check
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      answers_seen++;
      if (due_answers.size() == 0) begin
        note_mismatch("answer with no word outstanding");
      end else begin
        want = due_answers.pop_front();
        if (out_read_color !== want.color)
          note_mismatch($sformatf("answer %0d read_color %h, want %h",
                                  answers_seen, out_read_color, want.color));
        if (out_was_written !== want.written)
          note_mismatch($sformatf("answer %0d was_written %b, want %b",
                                  answers_seen, out_was_written, want.written));
        if (out_out_of_bounds !== want.oob)
          note_mismatch($sformatf("answer %0d out_of_bounds %b, want %b",
                                  answers_seen, out_out_of_bounds, want.oob));
      end
    end
  end

  // receiver: stretches of different stall patterns, plus one long hold-off
  initial begin : drain_side
    int mode;
    int stretch;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(3, 0);
      stretch = $urandom_range(150, 10);
      repeat (stretch) begin
        @(negedge clk);
        if (streaming && words_taken >= 300 && !backlog_done) begin
          backlog_done = 1'b1;
          out_ready <= 1'b0;
          repeat (BACKLOG_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1, 0));
          2: out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= ($urandom_range(7, 0) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    word_t w;
    int random_words;
    int phase_len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_point_color = '0;
    in_depth_test_on = 1'b0;
    in_clear_colors = 1'b0;
    in_clear_depths = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_w = 9'(COLS);
    frame_h = 9'(ROWS);
    clr_color_reg = '0;
    clr_depth_reg = '0;
    random_words = 0;

    // after reset: nothing stored yet, only out-of-frame and untested paths
    put_word(dtfb_pkg::OP_DRAW, -32768, 0, 0, 32'h0, 3'b100, 1, 0, 0, 1);
    put_word(dtfb_pkg::OP_READ, 256, 0, 0, 32'h0, 3'b000, 1, 0, 0, 1);
    put_word(OP_UNUSED, 5, 5, 5, 32'hFFFF_FFFF, 3'b111, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_DRAW, 0, 0, -32768, 32'hFFFF_FFFF, 3'b000, 1, 0, 1, 0);
    put_word(dtfb_pkg::OP_READ, 0, 0, 0, 32'h0, 3'b000, 1, 32'hFFFF_FFFF, 0, 0);
    // 3x2 frame cleared to the deepest depth
    put_reg(dtfb_pkg::REG_FRAME_WIDTH, 32'd3);
    put_reg(dtfb_pkg::REG_FRAME_HEIGHT, 32'd2);
    put_reg(dtfb_pkg::REG_CLEAR_COLOR, 32'h1234_5678);
    put_reg(dtfb_pkg::REG_CLEAR_DEPTH, 32'h0000_8000);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b011, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_READ, 2, 1, 0, 32'h0, 3'b000, 1, 32'h1234_5678, 0, 0);
    // equal depth loses, larger depth wins
    put_word(dtfb_pkg::OP_DRAW, 1, 1, -32768, 32'hAAAA_AAAA, 3'b100, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_DRAW, 1, 1, 32767, 32'hAAAA_AAAA, 3'b100, 1, 0, 1, 0);
    // untested draw: color only, depth stays at the maximum
    put_word(dtfb_pkg::OP_DRAW, 1, 1, -32768, 32'h5555_5555, 3'b000, 1, 0, 1, 0);
    put_word(dtfb_pkg::OP_DRAW, 1, 1, 32767, 32'h0F0F_0F0F, 3'b100, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_READ, 1, 1, 0, 32'h0, 3'b000, 1, 32'h5555_5555, 0, 0);
    put_word(dtfb_pkg::OP_READ, 3, 0, 0, 32'h0, 3'b000, 1, 0, 0, 1);
    put_word(dtfb_pkg::OP_READ, 0, -1, 0, 32'h0, 3'b000, 1, 0, 0, 1);
    // one store at a time, then neither
    put_reg(dtfb_pkg::REG_CLEAR_COLOR, 32'hFFFF_FFFF);
    put_reg(dtfb_pkg::REG_CLEAR_DEPTH, 32'h0000_7FFF);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b010, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_READ, 1, 1, 0, 32'h0, 3'b000, 1, 32'hFFFF_FFFF, 0, 0);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b001, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_DRAW, 0, 0, 32767, 32'h0123_4567, 3'b100, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b000, 1, 0, 0, 0);
    // empty frame: everything is outside, a clear touches nothing
    put_reg(dtfb_pkg::REG_FRAME_WIDTH, 32'd0);
    put_word(dtfb_pkg::OP_READ, 0, 0, 0, 32'h0, 3'b000, 1, 0, 0, 1);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b011, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_DRAW, 0, 0, 0, 32'h0, 3'b000, 1, 0, 0, 1);
    // width beyond the store limit acts as full width
    put_reg(dtfb_pkg::REG_FRAME_WIDTH, 32'd511);
    put_reg(dtfb_pkg::REG_FRAME_HEIGHT, 32'd1);
    put_word(dtfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 3'b010, 1, 0, 0, 0);
    put_word(dtfb_pkg::OP_READ, 255, 0, 0, 32'h0, 3'b000, 1, 32'hFFFF_FFFF, 0, 0);
    put_word(dtfb_pkg::OP_READ, 0, 1, 0, 32'h0, 3'b000, 1, 0, 0, 1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(script[i].reg_sel, script[i].reg_val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_word(script[i].w, script[i].typed, script[i].ans);
        pace();
      end
    end

    while (random_words < RANDOM_WORDS) begin
      settle();
      pick_frame();
      cfg_valid <= 1'b0;
      streaming = 1'b1;
      // open each phase with a clear so the frame holds data
      w = pick_word();
      w.opcode = dtfb_pkg::OP_CLEAR;
      if ($urandom_range(7, 0) != 0) {w.clr_color, w.clr_depth} = 2'b11;
      offer_word(w, 1'b0, '0);
      random_words++;
      pace();
      phase_len = $urandom_range(90, 30);
      repeat (phase_len) begin
        w = pick_word();
        offer_word(w, 1'b0, '0);
        if (w.opcode != OP_UNUSED) random_words++;
        pace();
      end
      streaming = 1'b0;
    end
    settle();
    repeat (20) @(posedge clk);

    $display("%0d words over %0d frame setups: %0d draws landed, %0d reads in frame",
             words_taken, frame_setups, draws_landed, reads_hit);
    $display("%0d clears walked, %0d out-of-frame answers, long output stall %s",
             clears_done, outside_count, backlog_done ? "applied" : "missed");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/dtfb_pkg.sv
rtl/dtfb_ram.sv
rtl/dtfb_front.sv
rtl/dtfb_queue.sv
rtl/dtfb_back.sv
rtl/depth_tested_frame_buffer.sv
rtl/dtfb_checker.sv
verif/testbench.sv
